/* design/faod_pkg.sv */
// Shared types and constants for the flow auto on/off detector.
// No dependencies; imported by faod_core and flow_auto_on_off_detector.
package faod_pkg;

   // Qualification limits
   localparam logic [7:0] OFF_RUN_LIMIT = 8'd200;
   localparam logic [2:0] TROUGH_LIMIT  = 3'd5;
   localparam logic [7:0] ARM_TIMEOUT   = 8'd150;

   // Register reset values
   localparam logic signed [15:0] PEAK_THRESHOLD_RESET   = 16'sd500;
   localparam logic signed [15:0] TROUGH_THRESHOLD_RESET = -16'sd400;
   localparam logic signed [15:0] OFF_THRESHOLD_RESET    = 16'sd10000;

   localparam int CSR_INDEX_WIDTH = 3;

   // Register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_AUTO_ON_ENABLE   = 3'd0,
      CSR_AUTO_OFF_ENABLE  = 3'd1,
      CSR_PEAK_THRESHOLD   = 3'd2,
      CSR_TROUGH_THRESHOLD = 3'd3,
      CSR_OFF_THRESHOLD    = 3'd4
   } csr_index_type;

   // Event flag bit positions
   localparam int EV_TEST_MASK   = 0;
   localparam int EV_CALIBRATE   = 1;
   localparam int EV_MACHINE_ON  = 2;
   localparam int EV_MACHINE_OFF = 3;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_OFF  = 2'd1,
      CMD_ON   = 2'd2
   } cmd_type;

   // Configuration handed to the detection core
   typedef struct packed {
      logic               auto_on_enable;
      logic               auto_off_enable;
      logic signed [15:0] peak_threshold;
      logic signed [15:0] trough_threshold;
      logic signed [15:0] off_threshold;
   } cfg_type;

endpackage

/* design/faod_core.sv */
// Detection state and per-sample decision logic.
// Depends on faod_pkg for the configuration struct, limits and command codes.
module faod_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic signed [15:0] flow,
   input  logic [3:0]         events,
   input  faod_pkg::cfg_type  cfg,
   output faod_pkg::cmd_type  command
);
   import faod_pkg::*;

   logic       peak_armed_ff, peak_armed_in;
   logic [2:0] trough_count_ff, trough_count_in;
   logic       breath_count_ff, breath_count_in;
   logic [7:0] arm_timer_ff, arm_timer_in;
   logic [7:0] high_flow_count_ff, high_flow_count_in;

   logic clear_all;
   logic off_branch;
   logic on_branch;

   assign clear_all  = events[EV_TEST_MASK] || events[EV_CALIBRATE] ||
                       (!cfg.auto_on_enable && !cfg.auto_off_enable);
   assign off_branch = events[EV_MACHINE_ON] && cfg.auto_off_enable;
   assign on_branch  = events[EV_MACHINE_OFF] && cfg.auto_on_enable;

   // Next state and command for the sample in the input register
   always_comb begin
      peak_armed_in      = peak_armed_ff;
      trough_count_in    = trough_count_ff;
      breath_count_in    = breath_count_ff;
      arm_timer_in       = arm_timer_ff;
      high_flow_count_in = high_flow_count_ff;
      command            = CMD_NONE;
      if (clear_all || (!off_branch && !on_branch)) begin
         peak_armed_in      = 1'b0;
         trough_count_in    = '0;
         breath_count_in    = 1'b0;
         high_flow_count_in = '0;
      end else if (off_branch) begin
         // machine on: count sustained high flow
         peak_armed_in   = 1'b0;
         trough_count_in = '0;
         breath_count_in = 1'b0;
         if (flow >= cfg.off_threshold) begin
            if (high_flow_count_ff >= OFF_RUN_LIMIT) begin
               high_flow_count_in = '0;
               command            = CMD_OFF;
            end else begin
               high_flow_count_in = high_flow_count_ff + 8'd1;
            end
         end else begin
            high_flow_count_in = '0;
         end
      end else begin
         // machine off: breath detection
         high_flow_count_in = '0;
         if (flow > cfg.peak_threshold && !peak_armed_ff) begin
            peak_armed_in = 1'b1;
            arm_timer_in  = '0;
         end else if (flow < cfg.trough_threshold && peak_armed_ff) begin
            if (trough_count_ff >= TROUGH_LIMIT) begin
               trough_count_in = '0;
               peak_armed_in   = 1'b0;
               if (breath_count_ff) begin
                  breath_count_in = 1'b0;
                  command         = CMD_ON;
               end else begin
                  breath_count_in = 1'b1;
               end
            end else begin
               trough_count_in = trough_count_ff + 3'd1;
            end
         end else if (flow >= cfg.trough_threshold && (peak_armed_ff || breath_count_ff)) begin
            if (arm_timer_ff >= ARM_TIMEOUT) begin
               arm_timer_in    = '0;
               peak_armed_in   = 1'b0;
               trough_count_in = '0;
               breath_count_in = 1'b0;
            end else begin
               arm_timer_in = arm_timer_ff + 8'd1;
            end
         end
      end
   end

   // State registers advance only when the sample moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_armed_ff      <= 1'b0;
         trough_count_ff    <= '0;
         breath_count_ff    <= 1'b0;
         arm_timer_ff       <= '0;
         high_flow_count_ff <= '0;
      end else if (fire) begin
         peak_armed_ff      <= peak_armed_in;
         trough_count_ff    <= trough_count_in;
         breath_count_ff    <= breath_count_in;
         arm_timer_ff       <= arm_timer_in;
         high_flow_count_ff <= high_flow_count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_trough_bound: assert property (@(posedge clock) disable iff (reset)
      trough_count_ff <= TROUGH_LIMIT)
      else $error("trough count out of range");
   a_timer_bound: assert property (@(posedge clock) disable iff (reset)
      arm_timer_ff <= ARM_TIMEOUT)
      else $error("arm timer out of range");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(high_flow_count_ff) && $stable(arm_timer_ff))
      else $error("detector state moved without a request");
`endif

endmodule

/* design/flow_auto_on_off_detector.sv */
// Top level: configuration registers, input register, result register.
// Depends on faod_pkg and faod_core.
// An accepted request is held in the input register, then its result is loaded into the result register.
// Throughput: one request per cycle while results drain, set by the combinational decision logic in faod_core.
// The input register takes a new request while the result register still holds one.
// Reset (synchronous): thresholds and enables return to defaults, counters clear.
module flow_auto_on_off_detector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [15:0]                  req_flow_rate,
   input  logic [3:0]                          req_event_flags,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_command,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [faod_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                         csr_data
);
   import faod_pkg::*;

   cfg_type            cfg_ff;
   logic               s1_valid_ff;
   logic signed [15:0] s1_flow_ff;
   logic [3:0]         s1_events_ff;
   logic               rsp_valid_ff;
   cmd_type            rsp_command_ff;
   cmd_type            core_command;
   logic               advance;

   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_on_enable   <= 1'b0;
         cfg_ff.auto_off_enable  <= 1'b0;
         cfg_ff.peak_threshold   <= PEAK_THRESHOLD_RESET;
         cfg_ff.trough_threshold <= TROUGH_THRESHOLD_RESET;
         cfg_ff.off_threshold    <= OFF_THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AUTO_ON_ENABLE:   cfg_ff.auto_on_enable   <= csr_data[0];
            CSR_AUTO_OFF_ENABLE:  cfg_ff.auto_off_enable  <= csr_data[0];
            CSR_PEAK_THRESHOLD:   cfg_ff.peak_threshold   <= csr_data;
            CSR_TROUGH_THRESHOLD: cfg_ff.trough_threshold <= csr_data;
            CSR_OFF_THRESHOLD:    cfg_ff.off_threshold    <= csr_data;
            default: ;
         endcase
      end
   end

   // Input stage moves on when the result register is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_flow_ff   <= req_flow_rate;
         s1_events_ff <= req_event_flags;
      end
   end

   faod_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .flow    (s1_flow_ff),
      .events  (s1_events_ff),
      .cfg     (cfg_ff),
      .command (core_command)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_command_ff <= core_command;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;

`ifndef NO_ASSERTIONS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with an empty result register");
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted request lost from the input register");
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result not presented after the input stage moved on");
`endif

endmodule
